// ===== sv/cel_pkg.sv =====
// ----------------------------------------------------------------------------
// cel_pkg
// Shared constants and types for the cross-entropy loss forward block.
// ----------------------------------------------------------------------------
package cel_pkg;

  localparam int MAX_CLASSES_DEF   = 64;
  localparam int FRACTION_BITS_DEF = 24;

  localparam int PROB_W  = 25;
  localparam int CLASS_W = 6;
  localparam int LOSS_W  = 28;
  localparam int COUNT_W = 7;

  localparam logic [PROB_W-1:0] CLIP_LO  = 25'd2;
  localparam logic [PROB_W-1:0] CLIP_HI  = 25'd16777214;
  localparam logic [PROB_W-1:0] ONE_Q    = 25'd16777216;
  localparam logic [LOSS_W-1:0] LOSS_MAX = 28'hFFFFFFF;
  localparam logic [27:0]       LN2_Q28  = 28'd186065280;

  // configuration register indexes
  localparam logic [0:0] REG_LABEL_MODE  = 1'b0;
  localparam logic [0:0] REG_CLASS_COUNT = 1'b1;

  // log unit request/response
  typedef struct packed {
    logic              start;
    logic [PROB_W-1:0] x;
  } log_req_t;

  typedef struct packed {
    logic              done;
    logic [LOSS_W-1:0] loss;
  } log_rsp_t;

endpackage

// ===== sv/cel_log.sv =====
// ----------------------------------------------------------------------------
// cel_log
// Iterative -ln(x): normalize, 30 squaring steps of one shared multiplier,
// then a ln2 scale and round.
// ----------------------------------------------------------------------------
module cel_log (
  input  logic               clk,
  input  logic               rst,
  input  cel_pkg::log_req_t  req,
  output cel_pkg::log_rsp_t  rsp
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_NORM = 5'b00010,
    S_SQR  = 5'b00100,
    S_SCL  = 5'b01000,
    S_RND  = 5'b10000
  } lstate_t;

  lstate_t      state;
  logic [24:0]  x;
  logic [4:0]   k;
  logic [30:0]  m;
  logic [29:0]  f;
  logic [4:0]   step;
  logic [35:0]  lval;
  logic [63:0]  prod;
  logic [61:0]  sq;
  logic [31:0]  sq_sh;
  logic [4:0]   top;
  logic [63:0]  rnd;
  logic         done;
  logic [cel_pkg::LOSS_W-1:0] loss_sat;

  assign rsp = '{done: done, loss: loss_sat};

  // leading one of x (x nonzero)
  always_comb begin
    top = '0;
    for (int i = 0; i < 25; i++) begin
      if (x[i]) top = 5'(i);
    end
  end

  assign sq    = 62'(m) * 62'(m);
  assign sq_sh = sq[61:30];
  assign rnd   = prod + 64'(64'd1 << 33);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.start) begin
            x     <= req.x;
            state <= S_NORM;
          end
        end
        S_NORM: begin
          k     <= top;
          m     <= 31'({6'd0, x} << (5'd30 - top));
          f     <= '0;
          step  <= 5'd29;
          state <= S_SQR;
        end
        // one squaring per cycle, one bit of log2(m)
        S_SQR: begin
          if (sq_sh[31]) begin
            m       <= sq_sh[31:1];
            f[step] <= 1'b1;
          end else begin
            m <= sq_sh[30:0];
          end
          if (step == 5'd0) state <= S_SCL;
          step <= step - 5'd1;
        end
        S_SCL: begin
          if (k > 5'd24) lval <= '0;
          else if (k == 5'd24) lval <= '0;
          else lval <= {6'(5'd24 - k), 30'd0} - 36'(f);
          state <= S_RND;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (state == S_RND) begin
        done <= 1'b1;
      end
    end
  end

  // ln2 product registered while in S_RND
  always_ff @(posedge clk) begin
    if (state == S_RND) prod <= 64'(lval) * 64'(cel_pkg::LN2_Q28);
  end

  // prod valid the cycle done rises; round and saturate
  always_comb begin
    if (rnd[63:34] > 30'(cel_pkg::LOSS_MAX)) loss_sat = cel_pkg::LOSS_MAX;
    else loss_sat = rnd[61:34];
  end

endmodule

// ===== sv/crossentropy_loss_forward.sv =====
// ----------------------------------------------------------------------------
// crossentropy_loss_forward
// Streaming categorical cross-entropy loss, forward direction.
// ----------------------------------------------------------------------------
// Input words carry one class probability (Q1.24) with a target weight and
// true class; a row ends after class_count words, clamped to 2..64. A word
// is taken when in_valid is high and the input is not stalled. After the
// final word of a row the log unit runs (start, normalize, 30 squarings on
// the shared multiplier, scale, ln2 multiply and round); the input stalls
// meanwhile. The loss word (Q4.24) and zero_confidence flag then sit in an
// output register until taken, and the input stalls while that result
// waits. A zero confidence skips the log: its result is valid the cycle
// after the final word. The config channel writes label_mode (index 0) and
// class_count (index 1); the user must write them only while idle, which
// the block does not enforce. Reset clears position, sum, busy and output
// valid; label_mode goes to 0 and class_count to 2. When out_stall is high
// the result holds and the input stays stalled until the result is taken.
// ----------------------------------------------------------------------------
module crossentropy_loss_forward (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [cel_pkg::PROB_W-1:0]   probability,
  input  logic [cel_pkg::PROB_W-1:0]   target_weight,
  input  logic [cel_pkg::CLASS_W-1:0]  true_class,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [cel_pkg::LOSS_W-1:0]   loss,
  output logic                         zero_confidence,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [cel_pkg::COUNT_W-1:0]  cfg_data
);

  localparam int MAX_CLASSES = cel_pkg::MAX_CLASSES_DEF;
  localparam int FB          = cel_pkg::FRACTION_BITS_DEF;

  logic                        label_mode;
  logic [cel_pkg::COUNT_W-1:0] class_count;
  logic [cel_pkg::CLASS_W-1:0] class_position;
  logic [cel_pkg::PROB_W-1:0]  confidence_sum;
  logic                        busy;
  logic [cel_pkg::PROB_W-1:0]  pclip;
  logic [49:0]                 wprod;
  logic [25:0]                 term;
  logic [25:0]                 sum_add;
  logic [cel_pkg::PROB_W-1:0]  sum_next;
  logic [cel_pkg::COUNT_W-1:0] count_eff;
  logic                        row_end;
  logic                        in_acc;
  cel_pkg::log_req_t           lreq;
  cel_pkg::log_rsp_t           lrsp;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy || (out_valid && out_stall);
  assign in_acc    = in_valid && !in_stall;

  // clip, effective count
  always_comb begin
    pclip = probability;
    if (pclip < cel_pkg::CLIP_LO) pclip = cel_pkg::CLIP_LO;
    if (pclip > cel_pkg::CLIP_HI) pclip = cel_pkg::CLIP_HI;
    count_eff = class_count;
    if (count_eff < 7'd2) count_eff = 7'd2;
    if (count_eff > 7'(MAX_CLASSES)) count_eff = 7'(MAX_CLASSES);
  end

  // confidence update
  assign wprod   = 50'(pclip) * 50'(target_weight);
  assign term    = 26'((wprod + 50'(50'd1 << (FB - 1))) >> FB);
  assign sum_add = 26'(confidence_sum) + term;
  always_comb begin
    sum_next = confidence_sum;
    if (!label_mode) begin
      if (class_position == true_class) sum_next = pclip;
    end else begin
      sum_next = (sum_add > 26'(cel_pkg::ONE_Q)) ? cel_pkg::ONE_Q : sum_add[24:0];
    end
  end
  assign row_end = (7'(class_position) + 7'd1) >= count_eff;

  assign lreq = '{start: in_acc && row_end && (sum_next != '0), x: sum_next};

  cel_log u_log (
    .clk (clk),
    .rst (rst),
    .req (lreq),
    .rsp (lrsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      label_mode     <= 1'b0;
      class_count    <= 7'd2;
      class_position <= '0;
      confidence_sum <= '0;
      busy           <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_index == cel_pkg::REG_LABEL_MODE) label_mode <= cfg_data[0];
      if (cfg_valid && cfg_index == cel_pkg::REG_CLASS_COUNT) class_count <= cfg_data;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (in_acc) begin
        if (row_end) begin
          class_position <= '0;
          confidence_sum <= '0;
          if (sum_next == '0) begin
            out_valid       <= 1'b1;
            loss            <= cel_pkg::LOSS_MAX;
            zero_confidence <= 1'b1;
          end else begin
            busy <= 1'b1;
          end
        end else begin
          class_position <= class_position + 6'd1;
          confidence_sum <= sum_next;
        end
      end
      if (lrsp.done) begin
        busy            <= 1'b0;
        out_valid       <= 1'b1;
        loss            <= lrsp.loss;
        zero_confidence <= 1'b0;
      end
    end
  end

  // no input taken while the log unit runs
  a_busy_stall: assert property (@(posedge clk) disable iff (rst) busy |-> in_stall)
    else $error("input accepted during log");
  // a log result never lands on an untaken result
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    lrsp.done |-> !out_valid) else $error("result overrun");
  // position stays below MAX_CLASSES
  a_pos: assert property (@(posedge clk) disable iff (rst)
    7'(class_position) < 7'(MAX_CLASSES)) else $error("position out of range");

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Streams probability rows through the loss block under both label modes,
// row lengths and idling patterns, predicts each row loss and checks it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class loss_scoreboard;
  logic              mode;
  logic [6:0]        count;
  int unsigned       position;
  logic [25:0]       conf;
  logic [27:0]       loss_q[$];
  logic              zero_q[$];
  int                errors;
  int                rows;

  function new();
    mode = 1'b0; count = 7'd2; position = 0; conf = 26'd0; errors = 0; rows = 0;
  endfunction

  // -ln(x) in Q4.24 by repeated squaring of the normalized mantissa
  function logic [27:0] neg_log(logic [25:0] x);
    int          k;
    logic [63:0] m;
    logic [63:0] f;
    logic [63:0] whole;
    logic [63:0] l;
    logic [63:0] prod;
    k = 25;
    f = 0;
    while (k > 0 && !x[k]) k--;
    m = 64'(x) << (30 - k);
    for (int i = 1; i <= 30; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        f = f | (64'd1 << (30 - i));
      end
    end
    whole = (k <= 24) ? 64'(24 - k) : 64'd0;
    l = (whole << 30) - f;
    if (whole == 0 && f != 0) l = 0;
    prod = l * 64'd186065280;
    prod = (prod + (64'd1 << 33)) >> 34;
    return (prod > 64'd268435455) ? 28'hFFFFFFF : prod[27:0];
  endfunction

  // note one accepted input word
  function void note_word(logic [24:0] p_in, logic [24:0] w, logic [5:0] tc);
    int unsigned cnt;
    logic [49:0] p;
    logic [50:0] t;
    logic [51:0] s;
    cnt = (count < 2) ? 2 : ((count > 64) ? 64 : count);
    p = p_in;
    if (p < 2) p = 2;
    if (p > 16777214) p = 16777214;
    if (!mode) begin
      if (position == tc) conf = p[25:0];
    end else begin
      t = (p * w + 50'd8388608) >> 24;
      s = conf + t;
      conf = (s > 52'd16777216) ? 26'd16777216 : s[25:0];
    end
    if (position + 1 >= cnt) begin
      if (conf == 0) begin
        loss_q.push_back(28'hFFFFFFF);
        zero_q.push_back(1'b1);
      end else begin
        loss_q.push_back(neg_log(conf));
        zero_q.push_back(1'b0);
      end
      position = 0;
      conf = 26'd0;
    end else begin
      position++;
    end
  endfunction

  // compare one accepted result word
  function void check_result(logic [27:0] l, logic z);
    rows++;
    if (loss_q.size() == 0) begin
      $display("%0t: unexpected result loss=%0d zero=%0d", $time, l, z);
      errors++;
      return;
    end
    if (loss_q[0] !== l) begin
      $display("%0t: loss expected %0d actual %0d", $time, loss_q[0], l);
      errors++;
    end
    if (zero_q[0] !== z) begin
      $display("%0t: zero_confidence expected %0d actual %0d", $time, zero_q[0], z);
      errors++;
    end
    void'(loss_q.pop_front());
    void'(zero_q.pop_front());
  endfunction
endclass

module testbench;

  localparam int WATCHDOG = 20000;

  logic                         clk = 0;
  logic                         rst = 1;
  logic                         in_valid = 0;
  logic                         in_stall;
  logic [cel_pkg::PROB_W-1:0]   probability = 0;
  logic [cel_pkg::PROB_W-1:0]   target_weight = 0;
  logic [cel_pkg::CLASS_W-1:0]  true_class = 0;
  logic                         out_valid;
  logic                         out_stall = 0;
  logic [cel_pkg::LOSS_W-1:0]   loss;
  logic                         zero_confidence;
  logic                         cfg_valid = 0;
  logic                         cfg_ready;
  logic                         cfg_index = 0;
  logic [cel_pkg::COUNT_W-1:0]  cfg_data = 0;

  loss_scoreboard sb = new();
  int send_idle = 0;
  int recv_stall = 0;
  int quiet = 0;
  int words = 0;

  crossentropy_loss_forward uut (.*);

  always #10 clk = ~clk;

  // result side: random stall, check on acceptance
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(loss, zero_confidence);
      out_stall <= ($urandom_range(99) < recv_stall);
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG) begin
        $display("crossentropy_loss_forward: mismatch");
        $finish;
      end
    end
  end

  // one input word, with random lead-in idling; valid stays up afterwards
  task automatic send_word(logic [24:0] p, logic [24:0] w, logic [5:0] tc);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    probability <= p;
    target_weight <= w;
    true_class <= tc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(p, w, tc);
    words++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.loss_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // register write while idle
  task automatic write_reg(logic idx, logic [6:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == cel_pkg::REG_LABEL_MODE) sb.mode = val[0];
    else sb.count = val;
    @(posedge clk);
  endtask

  function automatic logic [24:0] rand_prob();
    case ($urandom_range(5))
      0: return 25'($urandom_range(3));
      1: return 25'(16777216 - $urandom_range(3));
      2: return 25'($urandom);
      default: return 25'($urandom_range(16777216));
    endcase
  endfunction

  function automatic logic [24:0] rand_weight();
    case ($urandom_range(4))
      0: return 25'd0;
      1: return 25'd16777216;
      2: return 25'($urandom);
      default: return 25'($urandom_range(16777216 / 4));
    endcase
  endfunction

  // one row with random content; mostly valid true class
  task automatic send_row(int n);
    logic [5:0] tc;
    tc = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(n - 1));
    for (int i = 0; i < n; i++) begin
      if (sb.mode) send_word(rand_prob(), (i == tc || $urandom_range(3) == 0) ?
                             rand_weight() : 25'd0, 6'($urandom));
      else send_word(rand_prob(), 25'($urandom), tc);
    end
  endtask

  initial begin
    int counts[6] = '{2, 64, 3, 7, 16, 5};
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: clipping extremes, zero confidence, saturation
    send_word(25'd0, 25'd0, 6'd0);        send_word(25'd16777216, 25'd0, 6'd0);
    send_word(25'd16777216, 25'd0, 6'd1); send_word(25'h1FFFFFF, 25'd0, 6'd1);
    send_word(25'd5, 25'd0, 6'd3);        send_word(25'd9, 25'd0, 6'd3);
    send_word(25'd8388608, 25'd0, 6'd63); send_word(25'd1, 25'd0, 6'd0);
    drain();
    write_reg(cel_pkg::REG_LABEL_MODE, 7'd1);
    send_word(25'd16777216, 25'd16777216, 6'd0);
    send_word(25'd16777216, 25'd16777216, 6'd0);
    send_word(25'd100, 25'd0, 6'd0);      send_word(25'd200, 25'd0, 6'd0);
    send_word(25'h1FFFFFF, 25'h1FFFFFF, 6'd0); send_word(25'd0, 25'h1FFFFFF, 6'd0);
    send_word(25'd8388608, 25'd8388608, 6'd0); send_word(25'd3, 25'd3, 6'd63);
    drain();
    write_reg(cel_pkg::REG_CLASS_COUNT, 7'd0);
    send_word(25'd4000000, 25'd16777216, 6'd0); send_word(25'd1000, 25'd0, 6'd0);
    drain();
    write_reg(cel_pkg::REG_CLASS_COUNT, 7'd127);
    send_row(64);
    drain();

    // random phases over modes, row lengths and idling
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 79; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 79; end
        default: begin send_idle = 14; recv_stall = 14; end
      endcase
      drain();
      write_reg(cel_pkg::REG_LABEL_MODE, 7'(ph[0] ^ ph[2]));
      write_reg(cel_pkg::REG_CLASS_COUNT, 7'(counts[ph % 6]));
      while (words < 40 + (ph + 1) * 88) begin
        send_row(sb.count > 64 ? 64 : (sb.count < 2 ? 2 : sb.count));
        if ($urandom_range(15) == 0) drain();
      end
    end

    drain();
    $display("Covered %0d input words and %0d row results across both label modes,",
             words, sb.rows);
    $display("row lengths from 2 to 64, and mixed sender and receiver idling.");
    if (sb.errors == 0 && sb.loss_q.size() == 0) begin
      $display("crossentropy_loss_forward: match");
    end else begin
      $display("crossentropy_loss_forward: mismatch");
    end
    $finish;
  end
endmodule
